[rtl/core/cau_pkg.sv]
// Shared types, codes and a helper function for the complex arithmetic unit.
package cau_pkg;

  localparam int FIELD_W          = 32;
  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_DATA_WIDTH   = 32;
  localparam int SAT_W            = 96;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [FIELD_W-1:0] first_re;
    logic signed [FIELD_W-1:0] first_im;
    logic signed [FIELD_W-1:0] second_re;
    logic signed [FIELD_W-1:0] second_im;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] result_re;
    logic signed [FIELD_W-1:0] result_im;
    logic [1:0]                status;
  } out_item_t;

  // Control flags that travel down the pipeline with each beat.
  typedef struct packed {
    logic valid;
    logic is_div;
    logic zero;
    logic neg_re;
    logic neg_im;
    logic sat;
  } ctl_t;

  // Saturates a sign-magnitude value to dw-bit two's complement.
  // Bit 32 of the return value is the saturation flag, bits above dw are zero.
  function automatic logic [FIELD_W:0] sat_mag(input logic neg,
                                               input logic [SAT_W-1:0] mag,
                                               input int unsigned dw);
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] val;
    logic [SAT_W-1:0] mask;
    logic             flag;
    lim  = SAT_W'(1) << (dw - 1);
    mask = (SAT_W'(1) << dw) - SAT_W'(1);
    flag = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        flag = 1'b1;
        val  = lim;
      end else begin
        val = mag;
      end
      val = SAT_W'(0) - val;
    end else begin
      if (mag > lim - SAT_W'(1)) begin
        flag = 1'b1;
        val  = lim - SAT_W'(1);
      end else begin
        val = mag;
      end
    end
    val = val & mask;
    return {flag, val[FIELD_W-1:0]};
  endfunction

endpackage

[rtl/core/cau_prep.sv]
// Front pipeline: operand capture, products, sums, magnitudes and non-divide results.
module cau_prep #(
  parameter int DW = cau_pkg::DEF_DATA_WIDTH,
  parameter int F  = cau_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cau_pkg::in_item_t   in_data,
  output cau_pkg::ctl_t       ctl,
  output logic [2*DW:0]       num_re,
  output logic [2*DW:0]       num_im,
  output logic [2*DW-1:0]     den,
  output logic [DW-1:0]       res_re,
  output logic [DW-1:0]       res_im
);

  localparam int SW = 2*DW + 2;
  localparam int MW = 2*DW + 1;
  localparam int PW = 2*DW;

  // Stage 0: operand capture.
  logic                 v0_r;
  logic [1:0]           op0_r;
  logic signed [DW-1:0] a1_r, b1_r, a2_r, b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
    op0_r <= in_data.req_type;
    a1_r  <= in_data.first_re[DW-1:0];
    b1_r  <= in_data.first_im[DW-1:0];
    a2_r  <= in_data.second_re[DW-1:0];
    b2_r  <= in_data.second_im[DW-1:0];
  end

  // Stage 1: the six products and the part-wise add or subtract.
  logic                 v1_r;
  logic [1:0]           op1_r;
  logic signed [PW-1:0] p_a1a2_r, p_b1b2_r, p_a1b2_r, p_b1a2_r, p_a2a2_r, p_b2b2_r;
  logic signed [DW:0]   as_re_r, as_im_r, as_re_nxt, as_im_nxt;

  always_comb begin
    if (op0_r == cau_pkg::OP_SUB) begin
      as_re_nxt = (DW+1)'(a1_r) - (DW+1)'(a2_r);
      as_im_nxt = (DW+1)'(b1_r) - (DW+1)'(b2_r);
    end else begin
      as_re_nxt = (DW+1)'(a1_r) + (DW+1)'(a2_r);
      as_im_nxt = (DW+1)'(b1_r) + (DW+1)'(b2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    op1_r    <= op0_r;
    p_a1a2_r <= a1_r * a2_r;
    p_b1b2_r <= b1_r * b2_r;
    p_a1b2_r <= a1_r * b2_r;
    p_b1a2_r <= b1_r * a2_r;
    p_a2a2_r <= a2_r * a2_r;
    p_b2b2_r <= b2_r * b2_r;
    as_re_r  <= as_re_nxt;
    as_im_r  <= as_im_nxt;
  end

  // Stage 2: exact sums of products or the part-wise sum or difference, selected by operation, and the divisor.
  logic                 v2_r;
  logic [1:0]           op2_r;
  logic signed [SW-1:0] s_re_r, s_im_r, s_re_nxt, s_im_nxt;
  logic [PW-1:0]        den_r;

  always_comb begin
    unique case (op1_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s_re_nxt = SW'(as_re_r);
        s_im_nxt = SW'(as_im_r);
      end
      cau_pkg::OP_MUL: begin
        s_re_nxt = SW'(p_a1a2_r) - SW'(p_b1b2_r);
        s_im_nxt = SW'(p_a1b2_r) + SW'(p_b1a2_r);
      end
      default: begin
        s_re_nxt = SW'(p_a1a2_r) + SW'(p_b1b2_r);
        s_im_nxt = SW'(p_b1a2_r) - SW'(p_a1b2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    op2_r  <= op1_r;
    s_re_r <= s_re_nxt;
    s_im_r <= s_im_nxt;
    den_r  <= $unsigned(p_a2a2_r) + $unsigned(p_b2b2_r);
  end

  // Stage 3: sign and magnitude; add, subtract and multiply finish here.
  logic          neg_re, neg_im;
  logic [MW-1:0] mag_re, mag_im, sh_re, sh_im;
  logic [cau_pkg::FIELD_W:0] sat_re, sat_im;
  cau_pkg::ctl_t ctl_r, ctl_nxt;
  logic [MW-1:0] num_re_r, num_im_r;
  logic [PW-1:0] den3_r;
  logic [DW-1:0] res_re_r, res_im_r;

  always_comb begin
    neg_re = s_re_r[SW-1];
    neg_im = s_im_r[SW-1];
    mag_re = neg_re ? MW'(-s_re_r) : MW'(s_re_r);
    mag_im = neg_im ? MW'(-s_im_r) : MW'(s_im_r);
    sh_re  = (op2_r == cau_pkg::OP_MUL) ? (mag_re >> F) : mag_re;
    sh_im  = (op2_r == cau_pkg::OP_MUL) ? (mag_im >> F) : mag_im;
    sat_re = cau_pkg::sat_mag(neg_re, cau_pkg::SAT_W'(sh_re), DW);
    sat_im = cau_pkg::sat_mag(neg_im, cau_pkg::SAT_W'(sh_im), DW);
    ctl_nxt.valid  = v2_r;
    ctl_nxt.is_div = (op2_r == cau_pkg::OP_DIV);
    ctl_nxt.zero   = (den_r == '0);
    ctl_nxt.neg_re = neg_re;
    ctl_nxt.neg_im = neg_im;
    ctl_nxt.sat    = sat_re[cau_pkg::FIELD_W] | sat_im[cau_pkg::FIELD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    num_re_r <= mag_re;
    num_im_r <= mag_im;
    den3_r   <= den_r;
    res_re_r <= sat_re[DW-1:0];
    res_im_r <= sat_im[DW-1:0];
  end

  assign ctl    = ctl_r;
  assign num_re = num_re_r;
  assign num_im = num_im_r;
  assign den    = den3_r;
  assign res_re = res_re_r;
  assign res_im = res_im_r;

endmodule

[rtl/core/cau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module cau_div #(
  parameter int DW = cau_pkg::DEF_DATA_WIDTH,
  parameter int F  = cau_pkg::DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cau_pkg::ctl_t   ctl_in,
  input  logic [2*DW:0]   num_re,
  input  logic [2*DW:0]   num_im,
  input  logic [2*DW-1:0] den_in,
  input  logic [DW-1:0]   res_re_in,
  input  logic [DW-1:0]   res_im_in,
  output cau_pkg::ctl_t   ctl_out,
  output logic [DW-1:0]   q_re,
  output logic [DW-1:0]   q_im,
  output logic            ovf_re,
  output logic            ovf_im,
  output logic [DW-1:0]   res_re_out,
  output logic [DW-1:0]   res_im_out
);

  localparam int CW = 3*DW + F + 2;
  localparam int PW = 2*DW;

  cau_pkg::ctl_t ctl_r    [0:DW];
  logic [CW-1:0] rem_re_r [0:DW];
  logic [CW-1:0] rem_im_r [0:DW];
  logic [PW-1:0] den_r    [0:DW];
  logic [DW-1:0] q_re_r   [0:DW];
  logic [DW-1:0] q_im_r   [0:DW];
  logic          ovf_re_r [0:DW];
  logic          ovf_im_r [0:DW];
  logic [DW-1:0] res_re_r [0:DW];
  logic [DW-1:0] res_im_r [0:DW];

  // Entry stage: a quotient that needs more than DW bits saturates anyway.
  logic [CW-1:0] n_re, n_im, d_top;

  always_comb begin
    n_re  = CW'(num_re) << F;
    n_im  = CW'(num_im) << F;
    d_top = CW'(den_in) << DW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_in;
    end
    rem_re_r[0] <= n_re;
    rem_im_r[0] <= n_im;
    den_r[0]    <= den_in;
    q_re_r[0]   <= '0;
    q_im_r[0]   <= '0;
    ovf_re_r[0] <= (n_re >= d_top);
    ovf_im_r[0] <= (n_im >= d_top);
    res_re_r[0] <= res_re_in;
    res_im_r[0] <= res_im_in;
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    localparam int SH = DW - 1 - k;
    logic [CW-1:0] trial;
    logic          hit_re, hit_im;

    always_comb begin
      trial  = CW'(den_r[k]) << SH;
      hit_re = (rem_re_r[k] >= trial);
      hit_im = (rem_im_r[k] >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
      rem_re_r[k+1] <= hit_re ? (rem_re_r[k] - trial) : rem_re_r[k];
      rem_im_r[k+1] <= hit_im ? (rem_im_r[k] - trial) : rem_im_r[k];
      den_r[k+1]    <= den_r[k];
      q_re_r[k+1]   <= {q_re_r[k][DW-2:0], hit_re};
      q_im_r[k+1]   <= {q_im_r[k][DW-2:0], hit_im};
      ovf_re_r[k+1] <= ovf_re_r[k];
      ovf_im_r[k+1] <= ovf_im_r[k];
      res_re_r[k+1] <= res_re_r[k];
      res_im_r[k+1] <= res_im_r[k];
    end
  end

  assign ctl_out    = ctl_r[DW];
  assign q_re       = q_re_r[DW];
  assign q_im       = q_im_r[DW];
  assign ovf_re     = ovf_re_r[DW];
  assign ovf_im     = ovf_im_r[DW];
  assign res_re_out = res_re_r[DW];
  assign res_im_out = res_im_r[DW];

endmodule

[rtl/core/cau_out.sv]
// Output stage: quotient saturation, status and the result register.
module cau_out #(
  parameter int DW = cau_pkg::DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cau_pkg::ctl_t      ctl,
  input  logic [DW-1:0]      q_re,
  input  logic [DW-1:0]      q_im,
  input  logic               ovf_re,
  input  logic               ovf_im,
  input  logic [DW-1:0]      res_re,
  input  logic [DW-1:0]      res_im,
  output logic               out_valid,
  output cau_pkg::out_item_t out_data
);

  logic [DW-1:0]             qv_re, qv_im;
  logic [cau_pkg::FIELD_W:0] sat_re, sat_im;
  cau_pkg::out_item_t        data_nxt, data_r;
  logic                      valid_r;

  always_comb begin
    qv_re  = ovf_re ? '1 : q_re;
    qv_im  = ovf_im ? '1 : q_im;
    sat_re = cau_pkg::sat_mag(ctl.neg_re, cau_pkg::SAT_W'(qv_re), DW);
    sat_im = cau_pkg::sat_mag(ctl.neg_im, cau_pkg::SAT_W'(qv_im), DW);
    if (ctl.is_div && ctl.zero) begin
      data_nxt.result_re = '0;
      data_nxt.result_im = '0;
      data_nxt.status    = cau_pkg::STATUS_DIV0;
    end else if (ctl.is_div) begin
      data_nxt.result_re = sat_re[cau_pkg::FIELD_W-1:0];
      data_nxt.result_im = sat_im[cau_pkg::FIELD_W-1:0];
      data_nxt.status    = (sat_re[cau_pkg::FIELD_W] | sat_im[cau_pkg::FIELD_W]) ?
                           cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
    end else begin
      data_nxt.result_re = cau_pkg::FIELD_W'(res_re);
      data_nxt.result_im = cau_pkg::FIELD_W'(res_im);
      data_nxt.status    = ctl.sat ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/complex_arith_unit.sv]
// Top level of the pipelined complex add, subtract, multiply and divide unit.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------
//  input    | start in, busy out      | in_data   (cau_pkg::in_item_t)
//  result   | out_valid strobe out    | out_data  (cau_pkg::out_item_t)
//
// One beat enters per cycle while busy is low; every operation passes through
// the same registers, the front pipeline, the divider and the output register,
// in that order. The depth is set by the one-bit-per-stage divider.
// Reset is synchronous and clears the valid bits; busy is high for one cycle
// after reset and low from then on. The result is shown for one cycle only,
// so the receiver has to take every beat as it comes.
module complex_arith_unit #(
  parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::in_item_t  in_data,
  output logic               out_valid,
  output cau_pkg::out_item_t out_data
);

  localparam int DW = DATA_WIDTH;

  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  cau_pkg::ctl_t   prep_ctl, div_ctl;
  logic [2*DW:0]   num_re, num_im;
  logic [2*DW-1:0] den;
  logic [DW-1:0]   res_re, res_im, dres_re, dres_im, q_re, q_im;
  logic            ovf_re, ovf_im;

  cau_prep #(.DW(DW), .F(FRAC_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start & ~busy_r),
    .in_data (in_data),
    .ctl     (prep_ctl),
    .num_re  (num_re),
    .num_im  (num_im),
    .den     (den),
    .res_re  (res_re),
    .res_im  (res_im)
  );

  cau_div #(.DW(DW), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (prep_ctl),
    .num_re    (num_re),
    .num_im    (num_im),
    .den_in    (den),
    .res_re_in (res_re),
    .res_im_in (res_im),
    .ctl_out   (div_ctl),
    .q_re      (q_re),
    .q_im      (q_im),
    .ovf_re    (ovf_re),
    .ovf_im    (ovf_im),
    .res_re_out(dres_re),
    .res_im_out(dres_im)
  );

  cau_out #(.DW(DW)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .q_re     (q_re),
    .q_im     (q_im),
    .ovf_re   (ovf_re),
    .ovf_im   (ovf_im),
    .res_re   (dres_re),
    .res_im   (dres_im),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

[rtl/core/cau_chk.sv]
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_chk #(
  parameter int DW = cau_pkg::DEF_DATA_WIDTH
) (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input cau_pkg::out_item_t out_data
);

  // Once busy has dropped after reset, it stays low and the unit never refuses a beat.
  a_never_busy: assert property (@(posedge clk) $past(rst_n) && rst_n |-> !busy)
    else $error("busy raised outside reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3))
    else $error("undefined status code");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == cau_pkg::STATUS_DIV0) |->
      (out_data.result_re == '0) && (out_data.result_im == '0))
    else $error("divide by zero with nonzero result");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.result_re >> DW) == '0) && ((out_data.result_im >> DW) == '0))
    else $error("result bits above the data width are set");

  a_idle_after_reset: assert property (@(posedge clk) !$past(rst_n) && rst_n |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind complex_arith_unit cau_chk #(.DW(DATA_WIDTH)) u_cau_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
